// ----- sv/sic_pkg.sv -----
// Package for sorted_index_intersection: field widths, defaults, opcode and FSM state types.
// No dependencies; sic_req_if, sic_rsp_if and sorted_index_intersection import it.
package sic_pkg;

	localparam int COL_W            = 31;
	localparam int PAYLOAD_W        = 64;
	localparam int DEF_LIST_DEPTH   = 32;
	localparam int DEF_VALUE_WIDTH  = 64;
	localparam int MAX_RESULTS      = 32;
	localparam int RESULT_CNT_W     = $clog2(MAX_RESULTS + 1);

	typedef enum logic [1:0] {
		OP_LOAD_A = 2'd0,
		OP_LOAD_B = 2'd1,
		OP_RUN    = 2'd2,
		OP_CLEAR  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FETCH,
		ST_COMPARE,
		ST_FINISH
	} state_t;

endpackage

// ----- sv/sic_req_if.sv -----
// Request channel of sorted_index_intersection: valid/ready plus one command beat.
// Depends on sic_pkg.
interface sic_req_if;
	import sic_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [1:0]           operation;
	logic [COL_W-1:0]     column;
	logic [COL_W-1:0]     row;
	logic [PAYLOAD_W-1:0] payload;

	modport source (output valid, output operation, output column, output row,
		output payload, input ready);
	modport sink (input valid, input operation, input column, input row,
		input payload, output ready);

endinterface

// ----- sv/sic_rsp_if.sv -----
// Result channel of sorted_index_intersection: valid/ready plus one match beat.
// Depends on sic_pkg.
interface sic_rsp_if;
	import sic_pkg::*;

	logic                 valid;
	logic                 ready;
	logic                 matched;
	logic [COL_W-1:0]     match_column;
	logic [COL_W-1:0]     match_row;
	logic [PAYLOAD_W-1:0] match_value;
	logic                 last;
	logic                 overflow;

	modport source (output valid, output matched, output match_column, output match_row,
		output match_value, output last, output overflow, input ready);
	modport sink (input valid, input matched, input match_column, input match_row,
		input match_value, input last, input overflow, output ready);

endinterface

// ----- sv/sic_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module sic_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- sv/sorted_index_intersection.sv -----
// Top level of sorted_index_intersection: list loading and two-pointer merge over list RAMs.
// Depends on sic_pkg, sic_req_if, sic_rsp_if and sic_ram.
//
//   channel  dir  beat
//   req      in   operation, column, row, payload
//   rsp      out  matched, match_column, match_row, match_value, last, overflow
//
// Loads and clear are taken in idle even while a result waits on rsp.
// A run does each merge step as a RAM read (FETCH), then a compare (COMPARE), for at most
// count_a+count_b-1 steps, then FINISH emits the final result; req is held off meanwhile.
// One match is held back until the next one or the end of the run so that last can be set.
// A match stalls while a match is held and the output register is full; reset clears counts and overflow.
module sorted_index_intersection
	import sic_pkg::*;
#(
	parameter int LIST_DEPTH  = sic_pkg::DEF_LIST_DEPTH,
	parameter int VALUE_WIDTH = sic_pkg::DEF_VALUE_WIDTH
) (
	input  logic      clk,
	input  logic      arst_n,
	sic_req_if.sink   req,
	sic_rsp_if.source rsp
);

	localparam int IDX_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
	localparam int CNT_W = $clog2(LIST_DEPTH + 1);
	localparam int B_W   = 2 * COL_W + VALUE_WIDTH;

	state_t state_q, state_d;

	logic [CNT_W-1:0]        count_a_q, count_b_q, i_q, j_q;
	logic [RESULT_CNT_W-1:0] n_q;
	logic                    overflow_q;
	logic                    hold_v_q;
	logic [COL_W-1:0]        hold_col_q, hold_row_q;
	logic [VALUE_WIDTH-1:0]  hold_val_q;

	logic                    out_valid_q, out_matched_q, out_last_q, out_ovf_q;
	logic [COL_W-1:0]        out_col_q, out_row_q;
	logic [VALUE_WIDTH-1:0]  out_val_q;

	logic ld_a, ld_b, clr, start, step_i, step_j, take_match, push_hold, push_final;
	logic a_room, b_room, out_free;

	logic [COL_W-1:0] a_col;
	logic [B_W-1:0]   b_rd;
	logic [COL_W-1:0] b_col, b_row;
	logic [VALUE_WIDTH-1:0] b_val;

	assign a_room   = count_a_q < CNT_W'(LIST_DEPTH);
	assign b_room   = count_b_q < CNT_W'(LIST_DEPTH);
	assign out_free = !out_valid_q || rsp.ready;

	assign {b_col, b_row, b_val} = b_rd;

	sic_ram #(
		.WIDTH(COL_W),
		.DEPTH(LIST_DEPTH)
	) u_ram_a (
		.clk   (clk),
		.we    (ld_a && a_room),
		.waddr (count_a_q[IDX_W-1:0]),
		.wdata (req.column),
		.raddr (i_q[IDX_W-1:0]),
		.rdata (a_col)
	);

	sic_ram #(
		.WIDTH(B_W),
		.DEPTH(LIST_DEPTH)
	) u_ram_b (
		.clk   (clk),
		.we    (ld_b && b_room),
		.waddr (count_b_q[IDX_W-1:0]),
		.wdata ({req.column, req.row, req.payload[VALUE_WIDTH-1:0]}),
		.raddr (j_q[IDX_W-1:0]),
		.rdata (b_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		ld_a       = 1'b0;
		ld_b       = 1'b0;
		clr        = 1'b0;
		start      = 1'b0;
		step_i     = 1'b0;
		step_j     = 1'b0;
		take_match = 1'b0;
		push_hold  = 1'b0;
		push_final = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (req.valid) begin
					case (op_t'(req.operation))
						OP_LOAD_A: ld_a = 1'b1;
						OP_LOAD_B: ld_b = 1'b1;
						OP_CLEAR:  clr  = 1'b1;
						OP_RUN: begin
							start   = 1'b1;
							state_d = ST_FETCH;
						end
						default: ;
					endcase
				end
			end
			ST_FETCH: begin
				if (i_q < count_a_q && j_q < count_b_q &&
					n_q < RESULT_CNT_W'(MAX_RESULTS)) begin
					state_d = ST_COMPARE;
				end else begin
					state_d = ST_FINISH;
				end
			end
			ST_COMPARE: begin
				if (a_col < b_col) begin
					step_i  = 1'b1;
					state_d = ST_FETCH;
				end else if (a_col > b_col) begin
					step_j  = 1'b1;
					state_d = ST_FETCH;
				end else if (!hold_v_q || out_free) begin
					take_match = 1'b1;
					push_hold  = hold_v_q;
					state_d    = ST_FETCH;
				end
			end
			ST_FINISH: begin
				if (out_free) begin
					push_final = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign req.ready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_a_q   <= '0;
			count_b_q   <= '0;
			overflow_q  <= 1'b0;
			i_q         <= '0;
			j_q         <= '0;
			n_q         <= '0;
			hold_v_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (clr) begin
				count_a_q  <= '0;
				count_b_q  <= '0;
				overflow_q <= 1'b0;
			end
			if (ld_a) begin
				if (a_room) begin
					count_a_q <= count_a_q + 1'b1;
				end else begin
					overflow_q <= 1'b1;
				end
			end
			if (ld_b) begin
				if (b_room) begin
					count_b_q <= count_b_q + 1'b1;
				end else begin
					overflow_q <= 1'b1;
				end
			end
			if (start) begin
				i_q      <= '0;
				j_q      <= '0;
				n_q      <= '0;
				hold_v_q <= 1'b0;
			end
			if (step_i || take_match) begin
				i_q <= i_q + 1'b1;
			end
			if (step_j || take_match) begin
				j_q <= j_q + 1'b1;
			end
			if (take_match) begin
				n_q      <= n_q + 1'b1;
				hold_v_q <= 1'b1;
			end
			if (push_final) begin
				hold_v_q <= 1'b0;
			end
			if (push_hold || push_final) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_match) begin
			hold_col_q <= a_col;
			hold_row_q <= b_row;
			hold_val_q <= b_val;
		end
		if (push_hold || push_final) begin
			out_matched_q <= hold_v_q;
			out_last_q    <= push_final;
			out_ovf_q     <= overflow_q;
			out_col_q     <= hold_v_q ? hold_col_q : '0;
			out_row_q     <= hold_v_q ? hold_row_q : '0;
			out_val_q     <= hold_v_q ? hold_val_q : '0;
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.matched      = out_matched_q;
	assign rsp.match_column = out_col_q;
	assign rsp.match_row    = out_row_q;
	assign rsp.match_value  = PAYLOAD_W'(out_val_q);
	assign rsp.last         = out_last_q;
	assign rsp.overflow     = out_ovf_q;

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_a_q <= CNT_W'(LIST_DEPTH) && count_b_q <= CNT_W'(LIST_DEPTH))
		else $error("list count beyond depth");

	a_compare_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_COMPARE |-> i_q < count_a_q && j_q < count_b_q)
		else $error("merge pointer beyond list end");

	a_result_cap: assert property (@(posedge clk) disable iff (!arst_n)
		n_q <= RESULT_CNT_W'(MAX_RESULTS))
		else $error("result count beyond cap");

	a_no_hold_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !hold_v_q)
		else $error("held match left after run");

	a_push_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		(push_hold || push_final) |-> out_free)
		else $error("result pushed into full output register");
`endif

endmodule
